// File: rtl/bts_pkg.sv
package bts_pkg;

  localparam int COORD_BITS_DEF = 12;

  // status codes
  localparam logic [1:0] ST_DRAWN   = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_OFFSCR  = 2'd2;
  localparam logic [1:0] ST_DEGEN   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_POS0   = 3'd0;
  localparam logic [2:0] REG_POS1   = 3'd1;
  localparam logic [2:0] REG_POS2   = 3'd2;
  localparam logic [2:0] REG_COL0   = 3'd3;
  localparam logic [2:0] REG_COL1   = 3'd4;
  localparam logic [2:0] REG_COL2   = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  localparam int NUM_STAGES = 14;

endpackage

// File: rtl/barycentric_triangle_pixel_shader_unit.sv
// Each accepted input beat moves through the registered stages in order to its result beat.
// Throughput: one pixel per cycle unless the output stalls; each stage holds one
// item and advances whenever the one after it is empty or moving (bubbles collapse).
// Most of the depth is the 8-step restoring divider, one quotient bit per stage.
// Reset (rst, synchronous, active high) empties the pipeline and loads
// register defaults: vertices and colors zero, screen 640 x 480.
module barycentric_triangle_pixel_shader_unit #(
  parameter int COORD_BITS = bts_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pixel_x [COORD_BITS-1:0], pixel_y [2*COORD_BITS-1:COORD_BITS], zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // red [7:0], green [15:8], blue [23:16], word_offset [47:24]
  output logic [47:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0] m_axis_tuser,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import bts_pkg::*;

  localparam int NS = NUM_STAGES;
  localparam int EXT = 17 - COORD_BITS;

  // ---------------- configuration registers ----------------
  logic [31:0] pos [3];
  logic [23:0] col [3];
  logic [12:0] scr_w, scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= '0; pos[1] <= '0; pos[2] <= '0;
      col[0] <= '0; col[1] <= '0; col[2] <= '0;
      scr_w  <= WIDTH_RST;
      scr_h  <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS0:   pos[0] <= cfg_data;
        REG_POS1:   pos[1] <= cfg_data;
        REG_POS2:   pos[2] <= cfg_data;
        REG_COL0:   col[0] <= cfg_data[23:0];
        REG_COL1:   col[1] <= cfg_data[23:0];
        REG_COL2:   col[2] <= cfg_data[23:0];
        REG_WIDTH:  scr_w  <= cfg_data[12:0];
        REG_HEIGHT: scr_h  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // ---------------- stall control ----------------
  // Stage i may load when it is empty or its content moves on.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------- stage 1: edges, bounding box, screen window ----------
  logic signed [16:0] vx [3];
  logic signed [16:0] vy [3];
  logic signed [16:0] px_in, py_in;
  logic signed [16:0] minx, maxx, miny, maxy;
  logic signed [16:0] half_w, half_h;
  logic signed [30:0] wpy_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = {pos[i][15], pos[i][15:0]};
      vy[i] = {pos[i][31], pos[i][31:16]};
    end
    px_in = {{EXT{s_axis_tdata[COORD_BITS-1]}}, s_axis_tdata[COORD_BITS-1:0]};
    py_in = {{EXT{s_axis_tdata[2*COORD_BITS-1]}},
             s_axis_tdata[2*COORD_BITS-1:COORD_BITS]};
    minx = vx[0]; maxx = vx[0]; miny = vy[0]; maxy = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < minx) minx = vx[i];
      if (vx[i] > maxx) maxx = vx[i];
      if (vy[i] < miny) miny = vy[i];
      if (vy[i] > maxy) maxy = vy[i];
    end
    half_w = {5'd0, scr_w[12:1]};
    half_h = {5'd0, scr_h[12:1]};
    wpy_full = $signed({1'b0, scr_w}) * py_in;
  end

  logic signed [16:0] px1, ux1, uy1, wvx1, wvy1, wx1, wy1;
  logic box1, scr1;
  logic [23:0] wpy1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px1  <= px_in;
      ux1  <= vx[1] - vx[0];
      uy1  <= vy[1] - vy[0];
      wvx1 <= vx[2] - vx[0];
      wvy1 <= vy[2] - vy[0];
      wx1  <= px_in - vx[0];
      wy1  <= py_in - vy[0];
      box1 <= (px_in >= minx) && (px_in < maxx) && (py_in >= miny) && (py_in < maxy);
      scr1 <= (px_in < half_w) && (px_in > -half_w) &&
              (py_in < half_h) && (py_in > -half_h);
      wpy1 <= wpy_full[23:0];
    end
  end

  // ---------------- stage 2: cross-product terms, word offset ----------
  logic [25:0] wh_full;
  logic signed [33:0] pd1, pd2, ps1, ps2, pt1, pt2;
  logic box2, scr2;
  logic [23:0] off2;

  assign wh_full = scr_w * scr_h;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pd1  <= ux1 * wvy1;
      pd2  <= uy1 * wvx1;
      ps1  <= wx1 * wvy1;
      ps2  <= wy1 * wvx1;
      pt1  <= ux1 * wy1;
      pt2  <= uy1 * wx1;
      box2 <= box1;
      scr2 <= scr1;
      off2 <= wh_full[24:1] + {12'd0, scr_w[12:1]} + {{7{px1[16]}}, px1} - wpy1;
    end
  end

  // ---------------- stage 3: D, s, t ----------------
  logic signed [34:0] d3, s3, t3;
  logic box3, scr3;
  logic [23:0] off3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d3   <= 35'(pd1) - 35'(pd2);
      s3   <= 35'(ps1) - 35'(ps2);
      t3   <= 35'(pt1) - 35'(pt2);
      box3 <= box2;
      scr3 <= scr2;
      off3 <= off2;
    end
  end

  // ---------------- stage 4: orientation fix, coverage, status ----------
  logic signed [34:0] dn, sn, tn;
  logic signed [35:0] st_sum;
  logic [1:0] status_c;

  always_comb begin
    dn = d3[34] ? -d3 : d3;
    sn = d3[34] ? -s3 : s3;
    tn = d3[34] ? -t3 : t3;
    st_sum = 36'(sn) + 36'(tn);
    if (d3 == '0) begin
      status_c = ST_DEGEN;
    end else if (!box3 || sn[34] || tn[34] || (st_sum > 36'(dn))) begin
      status_c = ST_OUTSIDE;
    end else if (!scr3) begin
      status_c = ST_OFFSCR;
    end else begin
      status_c = ST_DRAWN;
    end
  end

  logic [34:0] d4, a4, s4, t4;
  logic [1:0] st4;
  logic [23:0] off4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d4   <= dn;
      s4   <= sn;
      t4   <= tn;
      a4   <= dn - sn - tn;
      st4  <= status_c;
      off4 <= off3;
    end
  end

  // ---------------- stage 5: weight products ----------------
  logic [42:0] pa5 [3];
  logic [42:0] pb5 [3];
  logic [42:0] pc5 [3];
  logic [34:0] d5;
  logic [1:0] st5;
  logic [23:0] off5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        pa5[c] <= col[0][8*c +: 8] * a4;
        pb5[c] <= col[1][8*c +: 8] * s4;
        pc5[c] <= col[2][8*c +: 8] * t4;
      end
      d5   <= d4;
      st5  <= st4;
      off5 <= off4;
    end
  end

  // ---------------- stage 6: numerators ----------------
  logic [43:0] num6 [3];
  logic [34:0] d6;
  logic [1:0] st6;
  logic [23:0] off6;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 3; c++) begin
        num6[c] <= 44'(pa5[c]) + 44'(pb5[c]) + 44'(pc5[c]);
      end
      d6   <= d5;
      st6  <= st5;
      off6 <= off5;
    end
  end

  // ---------------- stages 7..14: restoring divide, one bit each --------
  // Quotient never exceeds 255 since the weights sum to D.
  logic [43:0] rem [8][3];
  logic [7:0]  quo [8][3];
  logic [34:0] dd  [8];
  logic [1:0]  dst [8];
  logic [23:0] doff [8];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      if (en[6+k]) begin
        for (int c = 0; c < 3; c++) begin
          logic [43:0] r_in;
          logic [7:0]  q_in;
          logic [43:0] dsh;
          r_in = (k == 0) ? num6[c] : rem[(k == 0) ? 0 : k-1][c];
          q_in = (k == 0) ? 8'd0 : quo[(k == 0) ? 0 : k-1][c];
          dsh  = 44'(k == 0 ? d6 : dd[(k == 0) ? 0 : k-1]) << (7 - k);
          if (r_in >= dsh) begin
            rem[k][c] <= r_in - dsh;
            quo[k][c] <= q_in | (8'd1 << (7 - k));
          end else begin
            rem[k][c] <= r_in;
            quo[k][c] <= q_in;
          end
        end
        dd[k]   <= (k == 0) ? d6 : dd[(k == 0) ? 0 : k-1];
        dst[k]  <= (k == 0) ? st6 : dst[(k == 0) ? 0 : k-1];
        doff[k] <= (k == 0) ? off6 : doff[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- output ----------------
  logic drawn;
  assign drawn = (dst[7] == ST_DRAWN);

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tuser  = dst[7];
  assign m_axis_tdata  = drawn ? {doff[7], quo[7][2], quo[7][1], quo[7][0]} : 48'd0;

  // ---------------- checks ----------------
  a_zero_unless_drawn: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_DRAWN) |-> (m_axis_tdata == 48'd0))
    else $error("result fields not zero for a pixel that is not drawn");

  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> s_axis_tready)
    else $error("input stalled with an empty first stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    $past(m_axis_tvalid && !m_axis_tready) && !$past(rst) |->
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed under stall");

endmodule
